FILE: rtl/trsd_pkg.sv
`timescale 1ns / 1ps

package trsd_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [4:0] IDX_ID_LEN = 5'd0;
   localparam logic [4:0] IDX_CMAP   = 5'd1;
   localparam logic [4:0] IDX_TYPE   = 5'd2;
   localparam logic [4:0] IDX_W_LO   = 5'd12;
   localparam logic [4:0] IDX_W_HI   = 5'd13;
   localparam logic [4:0] IDX_H_LO   = 5'd14;
   localparam logic [4:0] IDX_H_HI   = 5'd15;
   localparam logic [4:0] IDX_DEPTH  = 5'd16;
   localparam logic [4:0] IDX_DESC   = 5'd17;

   localparam logic [7:0] TYPE_RLE_COLOR = 8'd10;
   localparam logic [7:0] TYPE_RLE_GRAY  = 8'd11;

   localparam int DESC_TOP_BIT = 5;
   localparam int PKT_RUN_BIT  = 7;

   localparam logic [1:0] ERR_TRUNC_HEADER = 2'd0;
   localparam logic [1:0] ERR_UNSUPPORTED  = 2'd1;
   localparam logic [1:0] ERR_TRUNC_RAW    = 2'd2;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_IDSKIP,
      PH_PKTHDR,
      PH_PIXEL,
      PH_IDLE
   } phase_type;

   typedef enum logic [1:0] {
      KIND_INFO,
      KIND_PIXEL,
      KIND_DONE,
      KIND_ERROR
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] pixel_value;
      logic [7:0]  repeat_res;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [2:0]  channel_count;
      logic        origin_top;
      logic [1:0]  error_code;
      logic [31:0] missing_pixels;
   } result_type;

   // The second word of a byte is always a done or an error word.
   typedef struct packed {
      kind_type    kind;
      logic [1:0]  error_code;
      logic [31:0] missing_pixels;
   } tail_type;

   typedef struct packed {
      result_type head;
      logic       has_tail;
      tail_type   tail;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic logic chan_legal(input logic [4:0] ch);
      chan_legal = (ch == 5'd1) || (ch == 5'd3) || (ch == 5'd4);
   endfunction

   function automatic result_type tail_to_result(input tail_type t);
      result_type r;
      r = '0;
      r.kind = t.kind;
      r.error_code = t.error_code;
      r.missing_pixels = t.missing_pixels;
      tail_to_result = r;
   endfunction

endpackage

FILE: rtl/trsd_front.sv
`timescale 1ns / 1ps

module trsd_front
   import trsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_file,
   input  qstat_type  q_stat,
   output logic       q_push,
   output entry_type  q_entry
);

   logic accept;

   phase_type phase_ff, phase_in, phase_mid;
   logic [4:0]  hdr_idx_ff, hdr_idx_in;
   logic [7:0]  id_skip_ff, id_skip_in;
   logic [7:0]  id_len_ff, id_len_in;
   logic [7:0]  cmap_ff, cmap_in;
   logic [7:0]  img_type_ff, img_type_in;
   logic [7:0]  depth_ff, depth_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [2:0]  chan_ff, chan_in;
   logic        rle_ff, rle_in;
   logic [7:0]  pkt_left_ff, pkt_left_in;
   logic        pkt_run_ff, pkt_run_in;
   logic [31:0] pix_buf_ff, pix_buf_in;
   logic [1:0]  byte_k_ff, byte_k_in;
   logic [31:0] pix_left_ff, pix_left_in;

   logic        hdr_done, hdr_rle, hdr_ok, eof_rle;
   logic [4:0]  hdr_chan;
   logic [31:0] area;
   logic [31:0] byte_ext, pix_word, pix_after;
   logic        pix_complete, is_run, run_covers, img_done;
   logic [7:0]  rep, pkt_after;

   result_type  r0;
   logic        r0_valid;
   tail_type    tail;
   logic        tail_valid;

   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;

   assign hdr_done = (hdr_idx_ff >= IDX_DESC);
   assign hdr_chan = depth_ff[7:3];
   assign hdr_rle  = (img_type_ff == TYPE_RLE_COLOR) || (img_type_ff == TYPE_RLE_GRAY);
   assign hdr_ok   = (cmap_ff == 8'd0) && (width_ff != 16'd0) && (height_ff != 16'd0) &&
                     chan_legal(hdr_chan);
   assign area     = {16'd0, width_ff} * {16'd0, height_ff};
   assign eof_rle  = (phase_ff == PH_HEADER) ? hdr_rle : rle_ff;

   assign byte_ext     = {24'd0, req_data_byte} << {byte_k_ff, 3'b000};
   assign pix_word     = pix_buf_ff | byte_ext;
   assign pix_complete = (({1'b0, byte_k_ff}) + 3'd1) >= chan_ff;
   assign is_run       = rle_ff && pkt_run_ff;
   assign run_covers   = {24'd0, pkt_left_ff} >= pix_left_ff;
   assign rep          = is_run ? (run_covers ? pix_left_ff[7:0] : pkt_left_ff) : 8'd1;
   assign pix_after    = pix_left_ff - {24'd0, rep};
   assign img_done     = is_run ? run_covers : (pix_left_ff == 32'd1);
   assign pkt_after    = is_run ? 8'd0 : (rle_ff ? pkt_left_ff - 8'd1 : pkt_left_ff);

   always_comb begin
      phase_mid = phase_ff;
      case (phase_ff)
         PH_HEADER: begin
            if (hdr_done) begin
               if (!hdr_ok) begin
                  phase_mid = PH_IDLE;
               end else if (id_len_ff != 8'd0) begin
                  phase_mid = PH_IDSKIP;
               end else begin
                  phase_mid = hdr_rle ? PH_PKTHDR : PH_PIXEL;
               end
            end
         end
         PH_IDSKIP: begin
            if (id_skip_ff == 8'd1) begin
               phase_mid = rle_ff ? PH_PKTHDR : PH_PIXEL;
            end
         end
         PH_PKTHDR: phase_mid = PH_PIXEL;
         PH_PIXEL: begin
            if (pix_complete) begin
               if (img_done) begin
                  phase_mid = PH_IDLE;
               end else if (rle_ff && (pkt_after == 8'd0)) begin
                  phase_mid = PH_PKTHDR;
               end
            end
         end
         PH_IDLE: phase_mid = PH_IDLE;
         default: phase_mid = PH_HEADER;
      endcase
      phase_in = phase_ff;
      if (accept) begin
         phase_in = req_end_of_file ? PH_HEADER : phase_mid;
      end
   end

   always_comb begin
      hdr_idx_in  = hdr_idx_ff;
      id_skip_in  = id_skip_ff;
      id_len_in   = id_len_ff;
      cmap_in     = cmap_ff;
      img_type_in = img_type_ff;
      depth_in    = depth_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      chan_in     = chan_ff;
      rle_in      = rle_ff;
      pkt_left_in = pkt_left_ff;
      pkt_run_in  = pkt_run_ff;
      pix_buf_in  = pix_buf_ff;
      byte_k_in   = byte_k_ff;
      pix_left_in = pix_left_ff;
      r0          = '0;
      r0_valid    = 1'b0;
      tail        = '0;
      tail_valid  = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_HEADER: begin
               case (hdr_idx_ff)
                  IDX_ID_LEN: id_len_in = req_data_byte;
                  IDX_CMAP:   cmap_in = req_data_byte;
                  IDX_TYPE:   img_type_in = req_data_byte;
                  IDX_W_LO:   width_in[7:0] = req_data_byte;
                  IDX_W_HI:   width_in[15:8] = req_data_byte;
                  IDX_H_LO:   height_in[7:0] = req_data_byte;
                  IDX_H_HI:   height_in[15:8] = req_data_byte;
                  IDX_DEPTH:  depth_in = req_data_byte;
                  default: ;
               endcase
               if (hdr_done) begin
                  hdr_idx_in = '0;
                  r0_valid = 1'b1;
                  if (!hdr_ok) begin
                     r0.kind = KIND_ERROR;
                     r0.error_code = ERR_UNSUPPORTED;
                  end else begin
                     r0.kind = KIND_INFO;
                     r0.image_width = width_ff;
                     r0.image_height = height_ff;
                     r0.channel_count = hdr_chan[2:0];
                     r0.origin_top = req_data_byte[DESC_TOP_BIT];
                     pix_left_in = area;
                     pix_buf_in = '0;
                     byte_k_in = '0;
                     pkt_left_in = '0;
                     pkt_run_in = 1'b0;
                     id_skip_in = id_len_ff;
                     chan_in = hdr_chan[2:0];
                     rle_in = hdr_rle;
                  end
               end else begin
                  hdr_idx_in = hdr_idx_ff + 5'd1;
               end
            end
            PH_IDSKIP: id_skip_in = id_skip_ff - 8'd1;
            PH_PKTHDR: begin
               pkt_left_in = {1'b0, req_data_byte[6:0]} + 8'd1;
               pkt_run_in = req_data_byte[PKT_RUN_BIT];
            end
            PH_PIXEL: begin
               if (pix_complete) begin
                  r0_valid = 1'b1;
                  r0.kind = KIND_PIXEL;
                  r0.pixel_value = pix_word;
                  r0.repeat_res = rep;
                  pkt_left_in = pkt_after;
                  pix_left_in = pix_after;
                  pix_buf_in = '0;
                  byte_k_in = '0;
                  if (img_done) begin
                     tail_valid = 1'b1;
                     tail.kind = KIND_DONE;
                  end
               end else begin
                  pix_buf_in = pix_word;
                  byte_k_in = byte_k_ff + 2'd1;
               end
            end
            default: ;
         endcase
         if (req_end_of_file) begin
            case (phase_mid)
               PH_HEADER: begin
                  tail_valid = 1'b1;
                  tail.kind = KIND_ERROR;
                  tail.error_code = ERR_TRUNC_HEADER;
               end
               PH_IDSKIP, PH_PKTHDR, PH_PIXEL: begin
                  tail_valid = 1'b1;
                  if (eof_rle) begin
                     tail.kind = KIND_DONE;
                     tail.missing_pixels = pix_left_in;
                  end else begin
                     tail.kind = KIND_ERROR;
                     tail.error_code = ERR_TRUNC_RAW;
                  end
               end
               default: ;
            endcase
            hdr_idx_in = '0;
            pix_buf_in = '0;
            byte_k_in = '0;
         end
      end
   end

   always_comb begin
      q_push = r0_valid || tail_valid;
      q_entry = '0;
      if (r0_valid) begin
         q_entry.head = r0;
         q_entry.has_tail = tail_valid;
         q_entry.tail = tail;
      end else begin
         q_entry.head = tail_to_result(tail);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         hdr_idx_ff  <= '0;
         id_skip_ff  <= '0;
         id_len_ff   <= '0;
         cmap_ff     <= '0;
         img_type_ff <= '0;
         depth_ff    <= '0;
         width_ff    <= '0;
         height_ff   <= '0;
         chan_ff     <= '0;
         rle_ff      <= 1'b0;
         pkt_left_ff <= '0;
         pkt_run_ff  <= 1'b0;
         pix_buf_ff  <= '0;
         byte_k_ff   <= '0;
         pix_left_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         hdr_idx_ff  <= hdr_idx_in;
         id_skip_ff  <= id_skip_in;
         id_len_ff   <= id_len_in;
         cmap_ff     <= cmap_in;
         img_type_ff <= img_type_in;
         depth_ff    <= depth_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         chan_ff     <= chan_in;
         rle_ff      <= rle_in;
         pkt_left_ff <= pkt_left_in;
         pkt_run_ff  <= pkt_run_in;
         pix_buf_ff  <= pix_buf_in;
         byte_k_ff   <= byte_k_in;
         pix_left_ff <= pix_left_in;
      end
   end

endmodule

FILE: rtl/trsd_queue.sv
`timescale 1ns / 1ps

module trsd_queue
   import trsd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output qstat_type q_stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   assign head         = slots_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/trsd_back.sv
`timescale 1ns / 1ps

module trsd_back
   import trsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  qstat_type   q_stat,
   input  entry_type   head,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_pixel_value,
   output logic [7:0]  rsp_repeat_res,
   output logic [15:0] rsp_image_width,
   output logic [15:0] rsp_image_height,
   output logic [2:0]  rsp_channel_count,
   output logic        rsp_origin_top,
   output logic [1:0]  rsp_error_code,
   output logic [31:0] rsp_missing_pixels,
   output logic        rsp_last_result
);

   logic       load;
   logic       valid_ff, valid_in;
   logic       second_ff, second_in;
   logic       last_ff, last_in;
   result_type out_ff, out_in;

   assign load = !q_stat.empty && (!valid_ff || rsp_ready);
   assign pop  = load && (second_ff || !head.has_tail);

   always_comb begin
      valid_in  = valid_ff;
      second_in = second_ff;
      last_in   = last_ff;
      out_in    = out_ff;
      if (load) begin
         valid_in = 1'b1;
         if (second_ff) begin
            out_in = tail_to_result(head.tail);
            last_in = 1'b1;
            second_in = 1'b0;
         end else begin
            out_in = head.head;
            last_in = !head.has_tail;
            second_in = head.has_tail;
         end
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      last_ff <= last_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_kind           = out_ff.kind;
   assign rsp_pixel_value    = out_ff.pixel_value;
   assign rsp_repeat_res     = out_ff.repeat_res;
   assign rsp_image_width    = out_ff.image_width;
   assign rsp_image_height   = out_ff.image_height;
   assign rsp_channel_count  = out_ff.channel_count;
   assign rsp_origin_top     = out_ff.origin_top;
   assign rsp_error_code     = out_ff.error_code;
   assign rsp_missing_pixels = out_ff.missing_pixels;
   assign rsp_last_result    = last_ff;

endmodule

FILE: rtl/tga_rle_stream_decoder_core.sv
`timescale 1ns / 1ps
// Path: a word passes from its accepted input byte through a queue entry and the output register
// before it is presented on the rsp side; a stalled rsp handshake holds it there.
// Throughput: one input byte per cycle while the queue has room; the rsp side delivers one word
// per cycle while rsp_ready is high, so a byte that causes two words holds the output for both.
// The input is held off while all QUEUE_DEPTH queue entries are occupied.
// Synchronous reset returns the parser to the header phase and drops queued words.

module tga_rle_stream_decoder_core
   import trsd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_pixel_value,
   output logic [7:0]  rsp_repeat_res,
   output logic [15:0] rsp_image_width,
   output logic [15:0] rsp_image_height,
   output logic [2:0]  rsp_channel_count,
   output logic        rsp_origin_top,
   output logic [1:0]  rsp_error_code,
   output logic [31:0] rsp_missing_pixels,
   output logic        rsp_last_result
);

   qstat_type q_stat;
   logic      q_push, q_pop;
   entry_type q_entry, q_head;

   trsd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_end_of_file (req_end_of_file),
      .q_stat          (q_stat),
      .q_push          (q_push),
      .q_entry         (q_entry)
   );

   trsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .q_stat     (q_stat)
   );

   trsd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_stat             (q_stat),
      .head               (q_head),
      .pop                (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_pixel_value    (rsp_pixel_value),
      .rsp_repeat_res     (rsp_repeat_res),
      .rsp_image_width    (rsp_image_width),
      .rsp_image_height   (rsp_image_height),
      .rsp_channel_count  (rsp_channel_count),
      .rsp_origin_top     (rsp_origin_top),
      .rsp_error_code     (rsp_error_code),
      .rsp_missing_pixels (rsp_missing_pixels),
      .rsp_last_result    (rsp_last_result)
   );

   a_pixel_repeat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_PIXEL) |-> rsp_repeat_res != 8'd0)
      else $error("pixel word with zero repeat count");

   a_info_channels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_INFO) |-> chan_legal({2'b00, rsp_channel_count}))
      else $error("info word with unsupported channel count");

   a_first_of_two: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> (rsp_kind == KIND_INFO) || (rsp_kind == KIND_PIXEL))
      else $error("done or error word not marked last");

   a_queue_push: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("queue written while full");

endmodule
